/* hw/rtl/tcm_pkg.sv */
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the texture column mapper: word formats,
// command, mode, status and configuration register codes, and the modulo unit's request/response.
// ----------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

	localparam int TEX_DEPTH  = 1024;
	localparam int TEX_AW     = $clog2(TEX_DEPTH);
	localparam int FRAC_WIDTH = 16;
	localparam int MAX_SCREEN = 2048;
	localparam int ADDR_W     = 22;
	localparam int HEIGHT_W   = 11;
	localparam int MAG_W      = 17;

	// command codes
	localparam logic [2:0] CMD_TEXEL   = 3'd0;
	localparam logic [2:0] CMD_LIGHT   = 3'd1;
	localparam logic [2:0] CMD_RECOLOR = 3'd2;
	localparam logic [2:0] CMD_BLEND   = 3'd3;
	localparam logic [2:0] CMD_START   = 3'd4;
	localparam logic [2:0] CMD_PIXEL   = 3'd5;

	// draw modes
	localparam logic [2:0] MODE_OPAQUE       = 3'd0;
	localparam logic [2:0] MODE_TRANSLATED   = 3'd1;
	localparam logic [2:0] MODE_TRANSLUCENT  = 3'd2;
	localparam logic [2:0] MODE_TRANS_TRANSL = 3'd3;
	localparam logic [2:0] MODE_FOG          = 3'd4;

	// result status
	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NO_COLUMN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_CENTER = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        table_index;
		logic [7:0]         table_value;
		logic [10:0]        column_x;
		logic signed [11:0] row_top;
		logic signed [11:0] row_bottom;
		logic signed [31:0] tex_mid;
		logic [30:0]        tex_step;
		logic [10:0]        tex_height;
		logic [2:0]         draw_mode;
		logic [7:0]         dest_pixel;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] pixel_address;
		logic [7:0]        pixel_color;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic                start;
		logic                neg;
		logic [MAG_W-1:0]    mag;
		logic [HEIGHT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [HEIGHT_W-1:0] rem;
	} mod_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/tcm_mod.sv */
// ----------------------------------------------------------------------------
// tcm_mod
// Bit-serial floor modulo of a signed integer (magnitude and sign) by the
// texture height, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_mod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcm_pkg::mod_req_t req,
	output tcm_pkg::mod_rsp_t      rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [4:0]                   cnt_q;
	logic [tcm_pkg::HEIGHT_W-1:0] rem_q;
	logic [tcm_pkg::MAG_W-1:0]    mag_q;
	logic                         neg_q;
	logic [tcm_pkg::HEIGHT_W-1:0] div_q;
	logic [tcm_pkg::HEIGHT_W-1:0] res_q;

	logic [tcm_pkg::HEIGHT_W:0]   trial;
	logic [tcm_pkg::HEIGHT_W:0]   trial_sub;
	logic [tcm_pkg::HEIGHT_W-1:0] rem_nx;
	logic [tcm_pkg::HEIGHT_W-1:0] fin;

	// shift in the next dividend bit, subtract when it fits
	assign trial     = {rem_q, mag_q[tcm_pkg::MAG_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign rem_nx    = (trial >= {1'b0, div_q}) ? trial_sub[tcm_pkg::HEIGHT_W-1:0]
		: trial[tcm_pkg::HEIGHT_W-1:0];
	// floor semantics for a negative dividend
	assign fin = (neg_q && rem_nx != '0) ? div_q - rem_nx : rem_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				mag_q  <= req.mag;
				neg_q  <= req.neg;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= rem_nx;
				mag_q <= {mag_q[tcm_pkg::MAG_W-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(tcm_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= fin;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = res_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("modulo unit started while busy");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> res_q < div_q)
		else $error("modulo result not below divisor");
`endif

endmodule

`default_nettype wire

/* hw/rtl/texture_column_mapper.sv */
// ----------------------------------------------------------------------------
// texture_column_mapper
// Vertical texture column drawer: table loads, column start, per-pixel
// address and color with wrapping for any texture height.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command word at a time.
//   Load commands write the texel, light, recolor or blend memory and
//   produce no result. A start word checks the column; a rejected
//   start returns one status word, an accepted one returns nothing.
//   Each pixel word returns one out word (out_valid/out_ready/out_data).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while the block is idle.
// Sequencing:
//   pixel: a chain of table reads through synchronous memories; opaque
//   reads texel then light, fog reads light of the dest pixel, translated
//   inserts recolor, translucent inserts blend, translated translucent
//   reads texel, recolor, light, blend, light. A non power of two height
//   whose stepped row leaves the texture adds a pass through the bit-serial
//   modulo unit. start: check, multiply, add, then the modulo unit for a non
//   power of two height. No new word is taken until the current one is done.
// Reset: registers go to 320/200/100, no column is active; memories are
//   undefined until loaded.
// Stall: a finished word waits in the output register; the next command is
//   taken meanwhile, and a new result holds until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_column_mapper (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tcm_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tcm_pkg::out_word_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [11:0]        cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MUL, S_ADD, S_MOD_START,
		S_PIX_TEX, S_PIX_REC, S_PIX_LT2, S_PIX_BLEND, S_PIX_LIGHT,
		S_MOD_PIX, S_OUT
	} state_t;

	state_t                       state_q;
	tcm_pkg::in_word_t            cur_q;
	tcm_pkg::out_word_t           res_q;
	tcm_pkg::out_word_t           out_q;
	logic                         out_valid_q;
	logic [11:0]                  width_q;
	logic [11:0]                  height_q;
	logic [10:0]                  center_q;
	logic [31:0]                  coord_q;
	logic [tcm_pkg::HEIGHT_W-1:0] h_q;
	logic                         pow2_q;
	logic [11:0]                  pixels_left_q;
	logic [tcm_pkg::ADDR_W-1:0]   addr_q;
	logic [2:0]                   mode_q;
	logic                         active_q;
	logic [31:0]                  prod_q;
	logic [15:0]                  frac_q;

	// table memories, read data registered
	logic [7:0] texel_mem  [tcm_pkg::TEX_DEPTH];
	logic [7:0] light_mem  [256];
	logic [7:0] recolor_mem[256];
	logic [7:0] blend_mem  [65536];
	logic [7:0] tex_rd_q;
	logic [7:0] light_rd_q;
	logic [7:0] rec_rd_q;
	logic [7:0] blend_rd_q;

	logic                       accept;
	logic [tcm_pkg::TEX_AW-1:0] tex_raddr;
	logic [tcm_pkg::TEX_AW-1:0] hmask;
	logic [7:0]                 light_raddr;
	logic [15:0]                blend_raddr;

	logic [11:0]                  sw_sat;
	logic [11:0]                  sh_sat;
	logic                         col_empty;
	logic                         col_range;
	logic [tcm_pkg::HEIGHT_W-1:0] h_cl;
	logic                         h_pow2;
	logic signed [12:0]           diff;
	logic signed [44:0]           prod_full;
	logic [22:0]                  row_base;
	logic [31:0]                  start_sum;
	logic [31:0]                  step_sum;
	logic                         step_wrap;
	tcm_pkg::mod_req_t            mod_req;
	tcm_pkg::mod_rsp_t            mod_rsp;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sw_sat = (width_q > 12'(tcm_pkg::MAX_SCREEN)) ? 12'(tcm_pkg::MAX_SCREEN) : width_q;
	assign sh_sat = (height_q > 12'(tcm_pkg::MAX_SCREEN)) ? 12'(tcm_pkg::MAX_SCREEN) : height_q;

	// start checks: empty first, then off screen
	assign col_empty = cur_q.row_bottom < cur_q.row_top;
	assign col_range = ({1'b0, cur_q.column_x} >= sw_sat) || cur_q.row_top[11]
		|| (!cur_q.row_bottom[11] && ({1'b0, cur_q.row_bottom[10:0]} >= sh_sat));

	// clamp height: zero acts as one, saturate at the texture depth
	assign h_cl = (cur_q.tex_height == '0) ? 11'd1
		: (cur_q.tex_height > 11'(tcm_pkg::TEX_DEPTH)) ? 11'(tcm_pkg::TEX_DEPTH)
		: cur_q.tex_height;
	assign h_pow2 = (h_cl & (h_cl - 11'd1)) == '0;

	assign diff      = $signed({2'b0, cur_q.row_top[10:0]}) - $signed({2'b0, center_q});
	assign prod_full = diff * $signed({1'b0, cur_q.tex_step});
	assign row_base  = {12'b0, cur_q.row_top[10:0]} * {11'b0, sw_sat};
	assign start_sum = cur_q.tex_mid + prod_q;
	assign step_sum  = coord_q + {1'b0, cur_q.tex_step};
	assign step_wrap = !pow2_q && (step_sum[31:16] >= {5'b0, h_q});

	// texel row: mask for power of two heights, already reduced otherwise
	assign hmask     = tcm_pkg::TEX_AW'(h_q - 11'd1);
	assign tex_raddr = pow2_q ? (coord_q[16 +: tcm_pkg::TEX_AW] & hmask)
		: coord_q[16 +: tcm_pkg::TEX_AW];

	always_comb begin
		light_raddr = tex_rd_q;
		blend_raddr = {tex_rd_q, cur_q.dest_pixel};
		case (state_q)
			S_PIX_TEX:   light_raddr = (mode_q == tcm_pkg::MODE_FOG) ? cur_q.dest_pixel : tex_rd_q;
			S_PIX_REC:   light_raddr = rec_rd_q;
			S_PIX_BLEND: light_raddr = blend_rd_q;
			S_PIX_LT2:   blend_raddr = {light_rd_q, cur_q.dest_pixel};
			default:     light_raddr = tex_rd_q;
		endcase
	end

	// modulo requests: start coordinate (signed) or stepped row (positive)
	always_comb begin
		mod_req.start   = 1'b0;
		mod_req.neg     = 1'b0;
		mod_req.mag     = {1'b0, step_sum[31:16]};
		mod_req.divisor = h_q;
		if (state_q == S_ADD) begin
			mod_req.start = !pow2_q;
			mod_req.neg   = start_sum[31];
			mod_req.mag   = start_sum[31] ? (17'd0 - {start_sum[31], start_sum[31:16]})
				: {1'b0, start_sum[31:16]};
		end else if (state_q == S_PIX_LIGHT) begin
			mod_req.start = step_wrap;
		end
	end

	tcm_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_ff @(posedge clk) begin
		if (accept && in_data.command == tcm_pkg::CMD_TEXEL
				&& in_data.table_index < 16'(tcm_pkg::TEX_DEPTH))
			texel_mem[in_data.table_index[tcm_pkg::TEX_AW-1:0]] <= in_data.table_value;
		tex_rd_q <= texel_mem[tex_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.command == tcm_pkg::CMD_LIGHT && in_data.table_index[15:8] == '0)
			light_mem[in_data.table_index[7:0]] <= in_data.table_value;
		light_rd_q <= light_mem[light_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.command == tcm_pkg::CMD_RECOLOR
				&& in_data.table_index[15:8] == '0)
			recolor_mem[in_data.table_index[7:0]] <= in_data.table_value;
		rec_rd_q <= recolor_mem[tex_rd_q];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.command == tcm_pkg::CMD_BLEND)
			blend_mem[in_data.table_index] <= in_data.table_value;
		blend_rd_q <= blend_mem[blend_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			width_q       <= 12'd320;
			height_q      <= 12'd200;
			center_q      <= 11'd100;
			coord_q       <= '0;
			h_q           <= '0;
			pow2_q        <= 1'b1;
			pixels_left_q <= '0;
			addr_q        <= '0;
			mode_q        <= '0;
			active_q      <= 1'b0;
		end else begin
			// configuration
			if (cfg_valid) begin
				case (cfg_index)
					tcm_pkg::CFG_WIDTH:  width_q  <= cfg_data;
					tcm_pkg::CFG_HEIGHT: height_q <= cfg_data;
					tcm_pkg::CFG_CENTER: center_q <= cfg_data[10:0];
					default: ;
				endcase
			end

			// drop the output word once taken; S_OUT handles its own refill
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q <= in_data;
						if (in_data.command == tcm_pkg::CMD_START) begin
							state_q <= S_CHECK;
						end else if (in_data.command == tcm_pkg::CMD_PIXEL) begin
							if (active_q) begin
								state_q <= S_PIX_TEX;
							end else begin
								res_q   <= '{status: tcm_pkg::ST_NO_COLUMN, default: '0};
								state_q <= S_OUT;
							end
						end
					end
				end
				S_CHECK: begin
					active_q <= 1'b0;
					if (col_empty) begin
						res_q   <= '{status: tcm_pkg::ST_EMPTY, default: '0};
						state_q <= S_OUT;
					end else if (col_range) begin
						res_q   <= '{status: tcm_pkg::ST_RANGE, default: '0};
						state_q <= S_OUT;
					end else begin
						h_q           <= h_cl;
						pow2_q        <= h_pow2;
						pixels_left_q <= 12'({1'b0, cur_q.row_bottom[10:0]}
							- {1'b0, cur_q.row_top[10:0]} + 12'd1);
						mode_q        <= cur_q.draw_mode;
						state_q       <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_full[31:0];
					addr_q  <= tcm_pkg::ADDR_W'(row_base + 23'(cur_q.column_x));
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (pow2_q) begin
						coord_q  <= start_sum;
						active_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						frac_q  <= start_sum[15:0];
						state_q <= S_MOD_START;
					end
				end
				S_MOD_START: begin
					if (mod_rsp.done) begin
						coord_q  <= {5'b0, mod_rsp.rem, frac_q};
						active_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_PIX_TEX: begin
					case (mode_q)
						tcm_pkg::MODE_TRANSLATED,
						tcm_pkg::MODE_TRANS_TRANSL: state_q <= S_PIX_REC;
						tcm_pkg::MODE_TRANSLUCENT:  state_q <= S_PIX_BLEND;
						default:                    state_q <= S_PIX_LIGHT;
					endcase
				end
				S_PIX_REC: begin
					state_q <= (mode_q == tcm_pkg::MODE_TRANS_TRANSL) ? S_PIX_LT2 : S_PIX_LIGHT;
				end
				S_PIX_LT2: begin
					state_q <= S_PIX_BLEND;
				end
				S_PIX_BLEND: begin
					state_q <= S_PIX_LIGHT;
				end
				S_PIX_LIGHT: begin
					res_q.status        <= tcm_pkg::ST_PIXEL;
					res_q.pixel_address <= addr_q;
					res_q.pixel_color   <= light_rd_q;
					res_q.last          <= pixels_left_q <= 12'd1;
					// advance one row
					addr_q <= addr_q + tcm_pkg::ADDR_W'(sw_sat);
					if (pixels_left_q != '0)
						pixels_left_q <= pixels_left_q - 12'd1;
					if (pixels_left_q <= 12'd1)
						active_q <= 1'b0;
					if (step_wrap) begin
						frac_q  <= step_sum[15:0];
						state_q <= S_MOD_PIX;
					end else begin
						coord_q <= step_sum;
						state_q <= S_OUT;
					end
				end
				S_MOD_PIX: begin
					if (mod_rsp.done) begin
						coord_q <= {5'b0, mod_rsp.rem, frac_q};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register frees
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_active_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && state_q == S_IDLE) |-> pixels_left_q != '0)
		else $error("active column with no pixels left");
	a_coord_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !pow2_q && state_q == S_IDLE) |-> coord_q[31:16] < {5'b0, h_q})
		else $error("texture row not reduced below height");
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != tcm_pkg::ST_PIXEL)
			|-> (out_q.pixel_color == '0 && !out_q.last && out_q.pixel_address == '0))
		else $error("status word carries pixel data");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_texture_column_mapper.sv */
// ----------------------------------------------------------------------------
// tb_texture_column_mapper
// Self-checking bench for the texture column mapper. Table loads, column
// starts and pixel words are driven over the in channel. A scoreboard class
// predicts every status and pixel word and compares it with the out channel.
// The run steps through several screen settings and idle/stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_texture_column_mapper;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 400;
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	// Column predictor and store of pending output words.
	class column_scoreboard;
		logic [7:0]  texels [tcm_pkg::TEX_DEPTH];
		logic [7:0]  light [256];
		logic [7:0]  recolor [256];
		logic [7:0]  blend [65536];
		bit          texel_w [tcm_pkg::TEX_DEPTH];
		bit          light_w [256];
		bit          recolor_w [256];
		bit          blend_w [65536];
		logic [31:0] coord;
		logic [26:0] height_fx;
		logic [11:0] left;
		logic [21:0] waddr;
		logic [2:0]  mode;
		bit          active;
		logic [11:0] width;
		logic [11:0] height;
		logic [10:0] center;
		tcm_pkg::out_word_t pending [$];
		int          errors;

		function new();
			coord = 0; height_fx = 0; left = 0; waddr = 0; mode = 0; active = 0;
			width = 320; height = 200; center = 100; errors = 0;
		endfunction

		function int sat(logic [11:0] v);
			return (v > tcm_pkg::MAX_SCREEN) ? tcm_pkg::MAX_SCREEN : int'(v);
		endfunction

		function bit is_pow2(int v);
			return (v & (v - 1)) == 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [11:0] val);
			case (idx)
				tcm_pkg::CFG_WIDTH:  width  = val;
				tcm_pkg::CFG_HEIGHT: height = val;
				tcm_pkg::CFG_CENTER: center = val[10:0];
				default: ;
			endcase
		endfunction

		function int cur_row();
			int h;
			int row;
			h = int'(height_fx >> tcm_pkg::FRAC_WIDTH);
			row = int'(coord >> tcm_pkg::FRAC_WIDTH);
			if (is_pow2(h))
				row = row & (h - 1);
			if (row >= tcm_pkg::TEX_DEPTH)
				row = 0;
			return row;
		endfunction

		// Find the first table entry that the next pixel would read unwritten.
		function bit missing(input logic [7:0] dest, output logic [2:0] cmd,
				output logic [15:0] idx);
			int row;
			logic [7:0] t;
			logic [7:0] lr;
			logic [15:0] bi;
			if (!active || (height_fx >> tcm_pkg::FRAC_WIDTH) == 0)
				return 0;
			row = cur_row();
			if (!texel_w[row]) begin
				cmd = tcm_pkg::CMD_TEXEL; idx = 16'(row); return 1;
			end
			t = texels[row];
			case (mode)
				tcm_pkg::MODE_TRANSLATED, tcm_pkg::MODE_TRANS_TRANSL: begin
					if (!recolor_w[t]) begin
						cmd = tcm_pkg::CMD_RECOLOR; idx = {8'd0, t}; return 1;
					end
					if (!light_w[recolor[t]]) begin
						cmd = tcm_pkg::CMD_LIGHT; idx = {8'd0, recolor[t]}; return 1;
					end
					if (mode == tcm_pkg::MODE_TRANSLATED)
						return 0;
					lr = light[recolor[t]];
					bi = {lr, dest};
				end
				tcm_pkg::MODE_TRANSLUCENT: bi = {t, dest};
				tcm_pkg::MODE_FOG: begin
					if (!light_w[dest]) begin
						cmd = tcm_pkg::CMD_LIGHT; idx = {8'd0, dest}; return 1;
					end
					return 0;
				end
				default: begin
					if (!light_w[t]) begin
						cmd = tcm_pkg::CMD_LIGHT; idx = {8'd0, t}; return 1;
					end
					return 0;
				end
			endcase
			if (!blend_w[bi]) begin
				cmd = tcm_pkg::CMD_BLEND; idx = bi; return 1;
			end
			if (!light_w[blend[bi]]) begin
				cmd = tcm_pkg::CMD_LIGHT; idx = {8'd0, blend[bi]}; return 1;
			end
			return 0;
		endfunction

		function void push(logic [1:0] st, logic [21:0] a, logic [7:0] c, logic l);
			tcm_pkg::out_word_t o;
			o.status = st; o.pixel_address = a; o.pixel_color = c; o.last = l;
			pending.push_back(o);
		endfunction

		function void start_column(tcm_pkg::in_word_t w);
			int sw;
			int sh;
			int top;
			int bot;
			int h;
			int diff;
			logic [63:0] prod;
			longint s;
			sw = sat(width);
			sh = sat(height);
			top = int'(w.row_top);
			bot = int'(w.row_bottom);
			active = 0;
			if (bot < top) begin
				push(tcm_pkg::ST_EMPTY, 0, 0, 0);
				return;
			end
			if (int'(w.column_x) >= sw || top < 0 || bot >= sh) begin
				push(tcm_pkg::ST_RANGE, 0, 0, 0);
				return;
			end
			h = int'(w.tex_height);
			if (h == 0) h = 1;
			if (h > tcm_pkg::TEX_DEPTH) h = tcm_pkg::TEX_DEPTH;
			height_fx = 27'(h << tcm_pkg::FRAC_WIDTH);
			left = 12'(bot - top + 1);
			waddr = 22'(top * sw + int'(w.column_x));
			mode = w.draw_mode;
			diff = top - int'(center);
			prod = {32'd0, 32'(diff)} * {33'd0, w.tex_step};
			coord = 32'(w.tex_mid) + prod[31:0];
			if (!is_pow2(h)) begin
				s = longint'($signed(coord)) % longint'(height_fx);
				if (s < 0) s += longint'(height_fx);
				coord = 32'(s);
			end
			active = 1;
		endfunction

		function void draw_pixel(tcm_pkg::in_word_t w);
			int h;
			logic [7:0] t;
			logic [7:0] c;
			logic [63:0] s;
			h = int'(height_fx >> tcm_pkg::FRAC_WIDTH);
			if (!active || h == 0) begin
				push(tcm_pkg::ST_NO_COLUMN, 0, 0, 0);
				return;
			end
			t = texels[cur_row()];
			case (mode)
				tcm_pkg::MODE_TRANSLATED:   c = light[recolor[t]];
				tcm_pkg::MODE_TRANSLUCENT:  c = light[blend[{t, w.dest_pixel}]];
				tcm_pkg::MODE_TRANS_TRANSL: c = light[blend[{light[recolor[t]], w.dest_pixel}]];
				tcm_pkg::MODE_FOG:          c = light[w.dest_pixel];
				default:                    c = light[t];
			endcase
			push(tcm_pkg::ST_PIXEL, waddr, c, left <= 1);
			waddr = waddr + 22'(sat(width));
			if (is_pow2(h))
				coord = coord + {1'b0, w.tex_step};
			else begin
				s = ({32'd0, coord} + {33'd0, w.tex_step}) % {37'd0, height_fx};
				coord = s[31:0];
			end
			if (left > 0) left--;
			if (left == 0) active = 0;
		endfunction

		// Note one accepted input word and queue what it causes.
		function void note_input(tcm_pkg::in_word_t w);
			case (w.command)
				tcm_pkg::CMD_TEXEL: if (w.table_index < tcm_pkg::TEX_DEPTH) begin
					texels[w.table_index] = w.table_value;
					texel_w[w.table_index] = 1;
				end
				tcm_pkg::CMD_LIGHT: if (w.table_index < 256) begin
					light[w.table_index] = w.table_value;
					light_w[w.table_index] = 1;
				end
				tcm_pkg::CMD_RECOLOR: if (w.table_index < 256) begin
					recolor[w.table_index] = w.table_value;
					recolor_w[w.table_index] = 1;
				end
				tcm_pkg::CMD_BLEND: begin
					blend[w.table_index] = w.table_value;
					blend_w[w.table_index] = 1;
				end
				tcm_pkg::CMD_START: start_column(w);
				tcm_pkg::CMD_PIXEL: draw_pixel(w);
				default: ;
			endcase
		endfunction

		function void check_result(tcm_pkg::out_word_t got);
			tcm_pkg::out_word_t exp;
			if (pending.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.pixel_address !== exp.pixel_address) begin
				$error("pixel_address: expected %0d, got %0d",
					exp.pixel_address, got.pixel_address);
				errors++;
			end
			if (got.pixel_color !== exp.pixel_color) begin
				$error("pixel_color: expected %0d, got %0d",
					exp.pixel_color, got.pixel_color);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	tcm_pkg::in_word_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 0;
	tcm_pkg::out_word_t out_data;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;

	column_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int words_sent = 0;
	int quiet_cycles = 0;
	logic [30:0] column_step;

	texture_column_mapper dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: check each accepted word, then pick next cycle's ready.
	// A hold-off request keeps ready low for a long stretch.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_data);
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n)
			out_ready <= 0;
		else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: count cycles in which no channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one word; keep valid high into the next word unless a gap falls.
	task automatic send_word(tcm_pkg::in_word_t w);
		bit lowered;
		lowered = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!lowered) in_valid <= 0;
			lowered = 1;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
		words_sent++;
	endtask

	function automatic tcm_pkg::in_word_t noise_word();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[$bits(tcm_pkg::in_word_t)-1:0];
	endfunction

	task automatic send_load(logic [2:0] cmd, logic [15:0] idx, logic [7:0] val);
		tcm_pkg::in_word_t w;
		w = noise_word();
		w.command = cmd; w.table_index = idx; w.table_value = val;
		send_word(w);
	endtask

	// Fill any table entry the pixel would read unwritten, then send it.
	task automatic send_pixel(logic [30:0] step, logic [7:0] dest);
		tcm_pkg::in_word_t w;
		logic [2:0] cmd;
		logic [15:0] idx;
		w = noise_word();
		w.command = tcm_pkg::CMD_PIXEL; w.tex_step = step; w.dest_pixel = dest;
		while (sb.missing(dest, cmd, idx))
			send_load(cmd, idx, 8'($urandom));
		send_word(w);
	endtask

	function automatic tcm_pkg::in_word_t make_start(int x, int top, int bot,
			logic [31:0] mid, logic [30:0] step, int h, logic [2:0] mode);
		tcm_pkg::in_word_t w;
		w = noise_word();
		w.command = tcm_pkg::CMD_START; w.column_x = 11'(x); w.row_top = 12'(top);
		w.row_bottom = 12'(bot); w.tex_mid = mid; w.tex_step = step;
		w.tex_height = 11'(h); w.draw_mode = mode;
		return w;
	endfunction

	// Start a column and follow it with pixels, mostly at the column's step.
	task automatic run_column(tcm_pkg::in_word_t w, int npix);
		send_word(w);
		column_step = w.tex_step;
		repeat (npix)
			send_pixel(($urandom_range(99) < 85) ? column_step : 31'($urandom),
				8'($urandom));
	endtask

	// Hold the sender until every result is back, then let the pipe settle.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic configure(logic [11:0] w, logic [11:0] h, logic [11:0] c);
		drain();
		write_reg(tcm_pkg::CFG_WIDTH, w);
		write_reg(tcm_pkg::CFG_HEIGHT, h);
		write_reg(tcm_pkg::CFG_CENTER, c);
	endtask

	// One random column, or noise now and then.
	task automatic random_column();
		int sw;
		int sh;
		int x;
		int top;
		int bot;
		int len;
		int h;
		int r;
		int npix;
		logic [30:0] step;
		tcm_pkg::in_word_t w;
		sw = sb.sat(sb.width);
		sh = sb.sat(sb.height);
		r = $urandom_range(99);
		if (r < 8) begin
			// a noise pixel still gets its table entries filled first
			w = noise_word();
			if (w.command == tcm_pkg::CMD_PIXEL)
				send_pixel(w.tex_step, w.dest_pixel);
			else
				send_word(w);
			return;
		end
		if (r < 14) begin
			send_load(3'($urandom_range(3)), 16'($urandom), 8'($urandom));
			return;
		end
		x = ($urandom_range(99) < 92) ? $urandom_range(sw - 1) : $urandom_range(2047);
		len = ($urandom_range(99) < 94) ? $urandom_range(1, 6) : $urandom_range(7, 40);
		top = $urandom_range(sh - 1);
		bot = top + len - 1;
		r = $urandom_range(99);
		if (r < 5) top = -int'($urandom_range(1, 2048));
		else if (r < 10) bot = top - int'($urandom_range(1, 20));
		else if (r < 88 && bot >= sh) bot = sh - 1;
		if (bot > 2047) bot = 2047;
		if (bot < -2048) bot = -2048;
		r = $urandom_range(99);
		if (r < 30) h = 1 << $urandom_range(10);
		else if (r < 80) h = $urandom_range(1, 1024);
		else if (r < 90) h = 0;
		else h = $urandom_range(1025, 2047);
		step = ($urandom_range(99) < 70) ? 31'($urandom_range(0, 1 << 18)) : 31'($urandom);
		npix = (bot >= top) ? bot - top + 1 : 1;
		if (npix > 40) npix = 3;
		if ($urandom_range(99) < 10) npix += $urandom_range(1, 2);
		run_column(make_start(x, top, bot, $urandom, step, h, 3'($urandom_range(7))), npix);
	endtask

	task automatic directed();
		send_load(tcm_pkg::CMD_BLEND, 16'hFFFF, 8'hFF);
		send_load(tcm_pkg::CMD_TEXEL, 16'd1023, 8'h00);
		send_load(tcm_pkg::CMD_TEXEL, 16'hFFFF, 8'hAA);      // beyond texel memory: dropped
		send_load(tcm_pkg::CMD_LIGHT, 16'h0100, 8'h55);      // beyond light map: dropped
		send_load(tcm_pkg::CMD_RECOLOR, 16'hFFFF, 8'h55);
		send_load(CMD_SPARE6, 16'($urandom), 8'($urandom));
		send_load(CMD_SPARE7, 16'($urandom), 8'($urandom));
		send_pixel(31'd65536, 8'h00);                        // no active column
		send_word(make_start(0, 5, 4, 0, 0, 16, tcm_pkg::MODE_OPAQUE));     // empty
		send_word(make_start(320, 0, 0, 0, 0, 16, tcm_pkg::MODE_OPAQUE));   // x off screen
		send_word(make_start(0, -1, 3, 0, 0, 16, tcm_pkg::MODE_OPAQUE));    // above top
		send_word(make_start(0, 190, 200, 0, 0, 16, tcm_pkg::MODE_OPAQUE)); // below bottom
		send_word(make_start(2047, -2048, 2047, 0, 0, 16, tcm_pkg::MODE_FOG));
		// every draw mode, including an unknown one drawn as opaque
		run_column(make_start(0, 0, 1, 0, 31'h10000, 128, tcm_pkg::MODE_OPAQUE), 2);
		run_column(make_start(319, 10, 11, 0, 31'h8000, 128, tcm_pkg::MODE_TRANSLATED), 2);
		run_column(make_start(5, 100, 101, 0, 31'h10000, 64, tcm_pkg::MODE_TRANSLUCENT), 2);
		run_column(make_start(6, 150, 151, 0, 31'h20000, 32, tcm_pkg::MODE_TRANS_TRANSL), 2);
		run_column(make_start(7, 199, 199, 0, 31'h10000, 8, tcm_pkg::MODE_FOG), 1);
		run_column(make_start(8, 3, 3, 0, 31'h10000, 8, 3'd7), 1);
		// height of zero, oversized height, non power of two heights with huge steps
		run_column(make_start(9, 20, 20, 32'h7FFFFFFF, 31'h10000, 0,
			tcm_pkg::MODE_OPAQUE), 1);
		run_column(make_start(9, 20, 21, 32'h7FFFFFFF, 31'h10000, 2047,
			tcm_pkg::MODE_OPAQUE), 2);
		run_column(make_start(1, 0, 2, 32'h80000000, 31'h7FFFFFFF, 100,
			tcm_pkg::MODE_OPAQUE), 3);
		run_column(make_start(2, 199, 199, 32'hFFFFFFFF, 31'h7FFFFFFF, 3,
			tcm_pkg::MODE_OPAQUE), 1);
		send_pixel(31'd0, 8'hFF);                            // column already finished
	endtask

	initial begin
		int quota;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		configure(12'd320, 12'd200, 12'd100);
		directed();
		quota = words_sent;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(12'd320, 12'd200, 12'd100);
				1: configure(12'd2048, 12'd2048, 12'd2047);
				2: configure(12'd1, 12'd1, 12'd0);
				3: configure(12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)),
					12'($urandom_range(2047)));
				4: configure(12'd2048, 12'd2048, 12'd0);
				5: configure(12'd4095, 12'd4095, 12'd1024);
				6: configure(12'($urandom_range(1, 640)), 12'($urandom_range(1, 480)),
					12'($urandom_range(2047)));
				default: configure(12'd64, 12'd48, 12'd24);
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			// long receiver hold-off while the sender keeps offering words
			if (p == 4) hold_request = HOLD_CYCLES;
			quota += 140;
			while (words_sent < quota)
				random_column();
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
